[hw/rtl/bole_pkg.sv]
// Shared types and constants for the bounded ordered list engine.
// No dependencies; every other source file imports this package.
`timescale 1ns / 1ps
package bole_pkg;

  localparam int OPCODE_W = 3;
  localparam int FIELD_W  = 5;
  localparam int VALUE_W  = 32;

  // cells examined per cycle by the search scan
  localparam int GROUP = 8;

  localparam logic [OPCODE_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_MODIFY = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SEARCH = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd5;

  localparam logic [FIELD_W-1:0] NOT_FOUND = 5'b11111;

  // broadcast command to every cell
  typedef struct packed {
    logic ins;
    logic del;
    logic mod;
    logic srch;
  } bole_ctl_t;

  // search scan status
  typedef struct packed {
    logic               busy;
    logic               done;
    logic               hit;
    logic [FIELD_W-1:0] index;
  } bole_scan_t;

endpackage

[hw/rtl/bole_if.sv]
// Request and response channel interfaces (valid/ready plus payload).
// Depends on bole_pkg for field widths.
`timescale 1ns / 1ps
interface bole_req_if;
  import bole_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic [FIELD_W-1:0]         position;
  logic signed [VALUE_W-1:0]  value;
  modport source (output valid, output opcode, output position, output value, input ready);
  modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

interface bole_rsp_if;
  import bole_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic signed [FIELD_W-1:0]  found_index;
  logic [FIELD_W-1:0]         count;
  modport source (output valid, output ok, output found_index, output count, input ready);
  modport sink   (input valid, input ok, input found_index, input count, output ready);
endinterface

[hw/rtl/bole_cell.sv]
// One list cell: holds one word, takes its neighbour's word on a shift,
// and registers whether it matches the search word.  Depends on bole_pkg.
`timescale 1ns / 1ps
module bole_cell #(
  parameter int IDX       = 0,
  parameter int CW        = 5,
  parameter int WORD_BITS = 32
) (
  input  logic                  clk,
  input  bole_pkg::bole_ctl_t   ctl,
  input  logic [CW-1:0]         pos,
  input  logic [CW-1:0]         cnt,
  input  logic [WORD_BITS-1:0]  val,
  input  logic [WORD_BITS-1:0]  left,
  input  logic [WORD_BITS-1:0]  right,
  output logic [WORD_BITS-1:0]  data,
  output logic                  match
);
  import bole_pkg::*;

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (MY_IDX == pos) begin
        data <= val;
      end else if (MY_IDX > pos) begin
        data <= left;
      end
    end else if (ctl.del) begin
      if (MY_IDX >= pos) begin
        data <= right;
      end
    end else if (ctl.mod) begin
      if (MY_IDX == pos) begin
        data <= val;
      end
    end
  end

  // held for the scan until the next search
  always_ff @(posedge clk) begin
    if (ctl.srch) begin
      match <= (data == val) && (MY_IDX < cnt);
    end
  end

endmodule

[hw/rtl/bole_scan.sv]
// Priority scan over the registered match bits, one group of cells a cycle.
// Depends on bole_pkg.
`timescale 1ns / 1ps
module bole_scan #(
  parameter int DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DEPTH-1:0]      match,
  output bole_pkg::bole_scan_t  stat
);
  import bole_pkg::*;

  localparam int NG   = (DEPTH + GROUP - 1) / GROUP;
  localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
  localparam int GB   = $clog2(GROUP);
  localparam int PADW = NG * GROUP;

  logic              busy;
  logic [GW-1:0]     grp;
  logic [PADW-1:0]   padded;
  logic [GROUP-1:0]  slice;
  logic [GB-1:0]     bsel;
  logic [GW+GB+FIELD_W-1:0] full_idx;
  logic              last;

  assign padded = PADW'(match);
  assign slice  = padded[grp*GROUP +: GROUP];
  assign last   = (grp == GW'(NG - 1));

  always_comb begin
    bsel = '0;
    for (int b = GROUP - 1; b >= 0; b--) begin
      if (slice[b]) bsel = GB'(b);
    end
  end

  assign full_idx = {{FIELD_W{1'b0}}, grp, bsel};

  always_comb begin
    stat.busy  = busy;
    stat.hit   = busy && (slice != '0);
    stat.done  = busy && ((slice != '0) || last);
    stat.index = full_idx[FIELD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      grp  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      grp  <= '0;
    end else if (busy) begin
      if (stat.done) begin
        busy <= 1'b0;
      end else begin
        grp <= grp + GW'(1);
      end
    end
  end

endmodule

[hw/rtl/bounded_ordered_list_engine.sv]
// Top level: request decode, cell chain, search scan and response register.
// Depends on bole_pkg, bole_if, bole_cell and bole_scan.
`timescale 1ns / 1ps
// The list lives in a row of DEPTH cells that shift as one on insert or
// delete, so for push, insert, delete, modify and clear the response word
// sits in the output register on the cycle after the request is taken.  A
// waiting response word holds off the next request until it leaves; a
// request can be taken in the cycle it leaves.  A search compares every
// cell in the accept cycle, then a priority scan walks the match bits eight
// cells a cycle; its response word is registered when the scan ends, and no
// request is taken meanwhile.  Failed operations change nothing.
// No reset sweep is needed: only cells below the count are ever read.
module bounded_ordered_list_engine #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  bole_req_if.sink   req,
  bole_rsp_if.source rsp
);
  import bole_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;

  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     cnt_next;
  logic [CW-1:0]        posx;
  logic [CW-1:0]        cntx;
  logic [CW-1:0]        cell_pos;
  logic [WORD_BITS-1:0] val_w;
  logic                 accept;
  logic                 full;
  logic                 ok_now;
  logic                 is_srch;
  bole_ctl_t            ctl;
  bole_scan_t           scan;

  logic [WORD_BITS-1:0] data [DEPTH];
  logic [WORD_BITS-1:0] left_d [DEPTH];
  logic [WORD_BITS-1:0] right_d [DEPTH];
  logic [DEPTH-1:0]     match;

  logic                 out_valid;
  logic                 out_ok;
  logic [FIELD_W-1:0]   out_found;
  logic [FIELD_W-1:0]   out_count;

  generate
    if (WORD_BITS > VALUE_W) begin : g_wide
      assign val_w = {{(WORD_BITS - VALUE_W){1'b0}}, req.value};
    end else if (WORD_BITS == VALUE_W) begin : g_same
      assign val_w = req.value;
    end else begin : g_narrow
      assign val_w = req.value[WORD_BITS-1:0];
    end
  endgenerate

  assign req.ready = !scan.busy && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign posx      = CW'(req.position);
  assign cntx      = CW'(cnt);
  assign full      = (cnt == CNT_W'(DEPTH));
  assign is_srch   = (req.opcode == OP_SEARCH);

  always_comb begin
    ok_now   = 1'b0;
    cnt_next = cnt;
    cell_pos = posx;
    ctl      = '0;
    case (req.opcode)
      OP_PUSH: begin
        cell_pos = '0;
        ok_now   = !full;
        ctl.ins  = accept && ok_now;
        if (ok_now) cnt_next = cnt + CNT_W'(1);
      end
      OP_INSERT: begin
        ok_now  = !full && (posx <= cntx);
        ctl.ins = accept && ok_now;
        if (ok_now) cnt_next = cnt + CNT_W'(1);
      end
      OP_DELETE: begin
        ok_now  = (posx < cntx);
        ctl.del = accept && ok_now;
        if (ok_now) cnt_next = cnt - CNT_W'(1);
      end
      OP_MODIFY: begin
        ok_now  = (posx < cntx);
        ctl.mod = accept && ok_now;
      end
      OP_SEARCH: begin
        ok_now   = 1'b1;
        ctl.srch = accept;
      end
      OP_CLEAR: begin
        ok_now   = 1'b1;
        cnt_next = '0;
      end
      default: begin
        ok_now = 1'b0;
      end
    endcase
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
        assign left_d[i] = val_w;
      end else begin : g_left
        assign left_d[i] = data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign right_d[i] = val_w;
      end else begin : g_right
        assign right_d[i] = data[i+1];
      end
      bole_cell #(
        .IDX       (i),
        .CW        (CW),
        .WORD_BITS (WORD_BITS)
      ) u_cell (
        .clk   (clk),
        .ctl   (ctl),
        .pos   (cell_pos),
        .cnt   (cntx),
        .val   (val_w),
        .left  (left_d[i]),
        .right (right_d[i]),
        .data  (data[i]),
        .match (match[i])
      );
    end
  endgenerate

  bole_scan #(
    .DEPTH (DEPTH)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.srch),
    .match (match),
    .stat  (scan)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (accept && !is_srch) begin
        out_valid <= 1'b1;
        out_ok    <= ok_now;
        out_found <= NOT_FOUND;
        out_count <= FIELD_W'(cnt_next);
      end else if (scan.done) begin
        out_valid <= 1'b1;
        out_ok    <= 1'b1;
        out_found <= scan.hit ? scan.index : NOT_FOUND;
        out_count <= FIELD_W'(cnt);
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.ok          = out_ok;
  assign rsp.found_index = out_found;
  assign rsp.count       = out_count;

  // no request is taken while a search scan runs
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    scan.busy |-> !req.ready)
    else $error("request taken during search scan");

  // the response slot is always free when a scan completes
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    scan.done |-> !out_valid)
    else $error("search result would overwrite a pending word");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // a non-search request yields a response word on the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    accept && !is_srch |=> out_valid)
    else $error("missing response word");

  // a search always leads into the scan
  a_srch_scan: assert property (@(posedge clk) disable iff (rst)
    accept && is_srch |=> scan.busy)
    else $error("search did not start scan");

endmodule

[sim/tb_bounded_ordered_list_engine.sv]
`timescale 1ns / 1ps
// Self-checking testbench for bounded_ordered_list_engine: list operations in, responses checked
// in order against a shadow copy of the list. Depends on bole_pkg, bole_if and the engine RTL.
module tb_bounded_ordered_list_engine;
  import bole_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_WORDS = 1200;
  localparam int CYCLE_LIMIT  = 200000;

  // opcodes the engine does not decode
  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

  localparam int GROW   = 0;
  localparam int SHRINK = 1;
  localparam int MIXED  = 2;

  typedef struct packed {
    logic               ok;
    logic [FIELD_W-1:0] found_index;
    logic [FIELD_W-1:0] count;
  } list_result_t;

  class list_shadow;
    logic [VALUE_W-1:0] entries [DEPTH];
    int unsigned        count;
    list_result_t       pending_results [$];
    int unsigned        mismatches;

    function void take_request(logic [OPCODE_W-1:0] op, logic [FIELD_W-1:0] pos,
                               logic [VALUE_W-1:0] val);
      list_result_t r;
      int unsigned  at;
      r.ok          = 1'b0;
      r.found_index = NOT_FOUND;
      at = (op == OP_PUSH) ? 0 : pos;
      case (op)
        OP_PUSH, OP_INSERT: begin
          if (count < DEPTH && at <= count) begin
            for (int i = count; i > at; i--) entries[i] = entries[i-1];
            entries[at] = val;
            count++;
            r.ok = 1'b1;
          end
        end
        OP_DELETE: begin
          if (at < count) begin
            for (int i = at; i + 1 < count; i++) entries[i] = entries[i+1];
            count--;
            r.ok = 1'b1;
          end
        end
        OP_MODIFY: begin
          if (at < count) begin
            entries[at] = val;
            r.ok = 1'b1;
          end
        end
        OP_SEARCH: begin
          r.ok = 1'b1;
          // walk downwards so the lowest matching position is the one kept
          for (int i = count - 1; i >= 0; i--)
            if (entries[i] == val) r.found_index = FIELD_W'(i);
        end
        OP_CLEAR: begin
          count = 0;
          r.ok  = 1'b1;
        end
        default: ;
      endcase
      r.count = FIELD_W'(count);
      pending_results.push_back(r);
    endfunction

    function void compare_field(string what, int want, int got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
    endfunction

    function void match_response(logic ok, logic [FIELD_W-1:0] found_index,
                                 logic [FIELD_W-1:0] cnt);
      list_result_t r;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected response word, expected none, got ok %0b index %0d count %0d",
                 $time, ok, $signed(found_index), cnt);
      end else begin
        r = pending_results.pop_front();
        compare_field("ok", r.ok, ok);
        compare_field("found_index", $signed(r.found_index), $signed(found_index));
        compare_field("count", r.count, cnt);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        no_idle = 1'b0;
  int unsigned cycles = 0;
  list_shadow  shadow;

  bole_req_if req ();
  bole_rsp_if rsp ();

  bounded_ordered_list_engine dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready) shadow.match_response(rsp.ok, rsp.found_index, rsp.count);
      if (req.valid && req.ready) shadow.take_request(req.opcode, req.position, req.value);
    end
  end

  function automatic int unsigned draw_wait();
    if (no_idle) return 0;
    return $urandom_range(0, 14);
  endfunction

  task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [FIELD_W-1:0] pos,
                           input logic [VALUE_W-1:0] val);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.opcode   <= op;
    req.position <= pos;
    req.value    <= val;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic pick_word(input int bias, output logic [OPCODE_W-1:0] op,
                           output logic [FIELD_W-1:0] pos, output logic [VALUE_W-1:0] val);
    int unsigned r;
    int unsigned ins_p;
    int unsigned del_p;
    int unsigned clr_p;
    int unsigned cnt;
    int unsigned k;
    cnt   = shadow.count;
    ins_p = (bias == GROW) ? 50 : (bias == SHRINK) ? 15 : 28;
    del_p = (bias == GROW) ? 10 : (bias == SHRINK) ? 45 : 25;
    clr_p = (bias == GROW) ? 0 : 2;
    r = $urandom_range(0, 99);
    if (r < ins_p) op = $urandom_range(0, 1) ? OP_INSERT : OP_PUSH;
    else if (r < ins_p + del_p) op = OP_DELETE;
    else if (r < ins_p + del_p + 12) op = OP_MODIFY;
    else if (r < 98 - clr_p) op = OP_SEARCH;
    else if (r < 98) op = OP_CLEAR;
    else op = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;

    k = $urandom_range(0, 9);
    if (k == 0) pos = FIELD_W'($urandom_range(0, 31));
    else if (k == 1) pos = FIELD_W'(cnt);  // edge: legal insert unless full, illegal delete/modify
    else if (op == OP_INSERT) pos = FIELD_W'($urandom_range(0, cnt));
    else pos = (cnt == 0) ? '0 : FIELD_W'($urandom_range(0, cnt - 1));

    if (op == OP_SEARCH && cnt > 0 && $urandom_range(0, 2) != 0) begin
      val = shadow.entries[$urandom_range(0, cnt - 1)];
    end else begin
      case ($urandom_range(0, 3))
        0: val = $urandom;
        1: case ($urandom_range(0, 2))
             0: val = 32'h7FFF_FFFF;
             1: val = 32'h8000_0000;
             default: val = 32'hFFFF_FFFF;
           endcase
        default: val = $urandom_range(0, 7);  // small pool so searches hit duplicates
      endcase
    end
  endtask

  // response side: random stalls before each word
  initial begin
    int unsigned stall;
    rsp.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  initial begin
    int unsigned         issued;
    int                  bias;
    logic [OPCODE_W-1:0] op;
    logic [FIELD_W-1:0]  pos;
    logic [VALUE_W-1:0]  val;
    shadow = new();
    req.valid    <= 1'b0;
    req.opcode   <= OP_PUSH;
    req.position <= '0;
    req.value    <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list, fill to full, edges of position and value
    send_word(OP_SEARCH, 0, 32'h0);
    send_word(OP_DELETE, 0, 32'h0);
    send_word(OP_INSERT, 1, 32'h0);
    send_word(OP_PUSH, 31, 32'h7FFF_FFFF);
    send_word(OP_INSERT, 1, 32'h8000_0000);
    for (int i = 2; i < DEPTH; i++)
      send_word(OP_INSERT, FIELD_W'(i), (i == DEPTH - 1) ? 32'hFFFF_FFFF : 32'(i % 3));
    send_word(OP_PUSH, 0, 32'h5);
    send_word(OP_INSERT, 16, 32'h5);
    send_word(OP_SEARCH, 0, 32'h1);
    send_word(OP_SEARCH, 0, 32'h1234_5678);
    send_word(OP_MODIFY, 15, 32'h0);
    send_word(OP_MODIFY, 16, 32'h0);
    send_word(OP_DELETE, 31, 32'h0);
    send_word(OP_DELETE, 0, 32'h0);
    send_word(OP_SPARE_LO, 0, 32'h0);
    send_word(OP_SPARE_HI, 31, 32'hFFFF_FFFF);
    send_word(OP_CLEAR, 0, 32'h0);

    issued = 0;
    bias   = MIXED;
    while (issued < RANDOM_WORDS) begin
      if (issued % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (issued % 100 == 0) bias = $urandom_range(GROW, MIXED);
      pick_word(bias, op, pos, val);
      send_word(op, pos, val);
      if (op != OP_SPARE_LO && op != OP_SPARE_HI) issued++;
    end
    req.valid <= 1'b0;
    @(posedge clk);

    while (shadow.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/bole_pkg.sv
hw/rtl/bole_if.sv
hw/rtl/bole_cell.sv
hw/rtl/bole_scan.sv
hw/rtl/bounded_ordered_list_engine.sv
sim/tb_bounded_ordered_list_engine.sv
